@@ rtl/subband_snr_voice_activity_top_assert.svh @@
// Assertion macros for the subband SNR voice activity detector.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef SUBBAND_SNR_VOICE_ACTIVITY_TOP_ASSERT_SVH
`define SUBBAND_SNR_VOICE_ACTIVITY_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SVAD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define SVAD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/svad_pkg.sv @@
// Package for the subband SNR voice activity detector.
// Types, sizes, register indexes and helpers shared by all modules; no dependencies.
package svad_pkg;

    localparam int NUM_BINS  = 256;
    localparam int NUM_BANDS = 32;
    localparam int BIN_AW    = $clog2(NUM_BINS);
    localparam int POS_W     = $clog2(NUM_BINS + 1);
    localparam int BAND_AW   = $clog2(NUM_BANDS);

    localparam logic [39:0] SUM_MAX    = 40'hFF_FFFF_FFFF;
    localparam logic [15:0] SNR_MIN    = 16'd4096;
    localparam logic [15:0] SNR_MAX    = 16'd40960;
    localparam logic [4:0]  FIRST_BAND = 5'd3;
    localparam logic [5:0]  BAND_LIM   = 6'(NUM_BANDS);
    localparam logic [5:0]  HITS_MAX   = 6'd63;
    localparam logic [15:0] CNT_MAX    = 16'hFFFF;
    localparam logic [16:0] ONE_Q16    = 17'd65536;

    // Register indexes
    typedef enum logic [2:0] {
        CFG_SNR_ALPHAS   = 3'd0,
        CFG_FLOOR_ALPHAS = 3'd1,
        CFG_BAND_SNR_THR = 3'd2,
        CFG_BAND_CNT_THR = 3'd3,
        CFG_FULL_SNR_THR = 3'd4,
        CFG_SPEECH_HOLD  = 3'd5,
        CFG_SILENCE_HOLD = 3'd6,
        CFG_ENERGY_LIMIT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] background_power;
        logic [31:0] signal_power;
        logic [4:0]  band_number;
        logic        in_band;
        logic        band_end;
        logic        frame_end;
    } t_in;

    typedef struct packed {
        logic        speech_active;
        logic [15:0] fullband_snr_out;
        logic [5:0]  speech_band_count;
        logic [39:0] floor_energy;
    } t_out;

    typedef struct packed {
        logic [31:0] snr_alphas;
        logic [47:0] floor_alphas;
        logic [15:0] band_snr_thr;
        logic [5:0]  band_cnt_thr;
        logic [15:0] full_snr_thr;
        logic [15:0] speech_hold;
        logic [15:0] silence_hold;
        logic [39:0] energy_limit;
    } t_cfg;

    // Work handed from the front to the back
    typedef struct packed {
        logic        is_band;
        logic        is_frame;
        logic [4:0]  band;
        logic [39:0] band_sig;
        logic [39:0] band_bkg;
        logic [39:0] frame_sig;
        logic [39:0] frame_bkg;
    } t_job;

    typedef struct packed {
        logic              we;
        logic [BIN_AW-1:0] addr;
        logic [31:0]       data;
    } t_store_wr;

    typedef struct packed {
        logic clearing;
        logic frame_done;
    } t_bstat;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_PREP, ST_DIV, ST_MUL, ST_APPLY, ST_WALK, ST_OUT
    } t_state;

    function automatic logic [39:0] sat_add(input logic [39:0] a, input logic [31:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {9'b0, b};
        return s[40] ? SUM_MAX : s[39:0];
    endfunction

endpackage

@@ rtl/svad_fifo.sv @@
// Two-entry job queue between the front and the back.
// Depends on svad_pkg for the job type.
module svad_fifo import svad_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_job   = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

@@ rtl/svad_front.sv @@
// Front part: accepts bins, keeps band and frame power sums, queues jobs.
// Depends on svad_pkg; feeds svad_fifo and the bin store in svad_back.
module svad_front import svad_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in       i_in_data,
    output logic      o_in_stall,
    input  t_bstat    i_bstat,
    input  logic      i_fifo_full,
    output logic      o_push,
    output t_job      o_job,
    output t_store_wr o_wr
);

    logic [39:0]      r_band_bkg, r_band_sig, r_frame_bkg, r_frame_sig;
    logic [POS_W-1:0] r_pos;
    logic             r_wait;
    logic             accept, inb;
    logic [39:0]      n_band_bkg, n_band_sig, n_frame_bkg, n_frame_sig;

    assign o_in_stall = r_wait | i_bstat.clearing | i_fifo_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign inb        = i_in_data.in_band & ({1'b0, i_in_data.band_number} < BAND_LIM);

    // Add this bin to the sums
    always_comb begin
        n_band_bkg  = r_band_bkg;
        n_band_sig  = r_band_sig;
        n_frame_bkg = r_frame_bkg;
        n_frame_sig = r_frame_sig;
        if (inb) begin
            n_band_bkg  = sat_add(r_band_bkg, i_in_data.background_power);
            n_band_sig  = sat_add(r_band_sig, i_in_data.signal_power);
            n_frame_bkg = sat_add(r_frame_bkg, i_in_data.background_power);
            n_frame_sig = sat_add(r_frame_sig, i_in_data.signal_power);
        end
    end

    // Build the job for the queue
    always_comb begin
        o_job.is_band   = inb & i_in_data.band_end;
        o_job.is_frame  = i_in_data.frame_end;
        o_job.band      = i_in_data.band_number;
        o_job.band_sig  = n_band_sig;
        o_job.band_bkg  = n_band_bkg;
        o_job.frame_sig = n_frame_sig;
        o_job.frame_bkg = n_frame_bkg;
        o_push          = accept & (o_job.is_band | o_job.is_frame);
        o_wr.we         = accept & (r_pos < POS_W'(NUM_BINS));
        o_wr.addr       = r_pos[BIN_AW-1:0];
        o_wr.data       = i_in_data.background_power;
    end

    // Update sums, bin position and the frame wait
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_bkg  <= '0;
            r_band_sig  <= '0;
            r_frame_bkg <= '0;
            r_frame_sig <= '0;
            r_pos       <= '0;
            r_wait      <= 1'b0;
        end else begin
            if (i_bstat.frame_done) r_wait <= 1'b0;
            if (accept) begin
                if (i_in_data.frame_end) begin
                    r_band_bkg  <= '0;
                    r_band_sig  <= '0;
                    r_frame_bkg <= '0;
                    r_frame_sig <= '0;
                    r_pos       <= '0;
                    r_wait      <= 1'b1;
                end else begin
                    r_frame_bkg <= n_frame_bkg;
                    r_frame_sig <= n_frame_sig;
                    if (o_job.is_band) begin
                        r_band_bkg <= '0;
                        r_band_sig <= '0;
                    end else begin
                        r_band_bkg <= n_band_bkg;
                        r_band_sig <= n_band_sig;
                    end
                    if (o_wr.we) r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/svad_back.sv @@
// Back part: SNR divide and smoothing, frame decision, floor walk, result register.
// Depends on svad_pkg and the assertion macro header.
`include "subband_snr_voice_activity_top_assert.svh"
module svad_back import svad_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_store_wr i_wr,
    input  logic      i_fifo_empty,
    input  t_job      i_job,
    output logic      o_pop,
    output t_bstat    o_bstat,
    output logic      o_out_valid,
    output t_out      o_out_data,
    input  logic      i_out_stall
);

    t_state r_state, n_state;
    t_job   r_job;
    logic   r_phase;

    // Divider
    logic [31:0] r_num_lo, r_quo;
    logic [40:0] r_rem, r_den;
    logic        r_sat;
    logic [4:0]  r_cnt;

    // Smoothing
    logic [31:0] r_p0;
    logic [48:0] r_p1;

    // Detector state
    logic [15:0] r_band_snr [NUM_BANDS];
    logic [15:0] r_full, r_spc, r_slc;
    logic        r_flag;
    logic [5:0]  r_hits;
    logic        r_walk_en;

    // Floor walk
    logic [31:0]        r_store [NUM_BINS];
    logic [31:0]        r_floor [NUM_BINS];
    logic [POS_W-1:0]   r_widx;
    logic               r_v1, r_v2;
    logic [BIN_AW-1:0]  r_idx1, r_idx2;
    logic [31:0]        r_x, r_old, r_old2;
    logic signed [50:0] r_prod;
    logic [39:0]        r_energy;

    logic        r_out_valid;
    t_out        r_out;

    logic        out_free, div_last, walk_done;
    logic [40:0] sig1, den1;
    logic [52:0] num;
    logic [41:0] rem2;
    logic        ge;
    logic [15:0] alpha, old_snr, snr_new;
    logic [31:0] inst;
    logic [49:0] psum;
    logic [33:0] vraw;
    logic        speech;
    logic [15:0] spc_inc, slc_inc;
    logic [BAND_AW-1:0] bidx;
    logic [15:0] a_sel;
    logic signed [32:0] diff;
    logic signed [50:0] oldx;
    logic [31:0] new_floor, floor_keep;
    logic        fl_we;
    logic [BIN_AW-1:0] fl_wa;
    logic [31:0] fl_wd;

    assign out_free  = ~r_out_valid | ~i_out_stall;
    assign div_last  = (r_cnt == 5'd0);
    assign walk_done = (r_widx == POS_W'(NUM_BINS)) & ~r_v1 & ~r_v2;
    assign bidx      = r_job.band[BAND_AW-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_widx == POS_W'(NUM_BINS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (!i_fifo_empty) n_state = ST_PREP;
            ST_PREP:  n_state = ST_DIV;
            ST_DIV:   if (div_last) n_state = ST_MUL;
            ST_MUL:   n_state = ST_APPLY;
            ST_APPLY: begin
                if (r_phase) n_state = ST_WALK;
                else if (r_job.is_frame) n_state = ST_PREP;
                else n_state = ST_IDLE;
            end
            ST_WALK:  if (walk_done) n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_pop              = (r_state == ST_IDLE) & ~i_fifo_empty;
        o_bstat.clearing   = (r_state == ST_CLEAR);
        o_bstat.frame_done = (r_state == ST_OUT) & out_free;
    end

    // Divider operands and step
    always_comb begin
        sig1 = r_phase ? ({1'b0, r_job.frame_sig} + 41'd1) : ({1'b0, r_job.band_sig} + 41'd1);
        den1 = r_phase ? ({1'b0, r_job.frame_bkg} + 41'd1) : ({1'b0, r_job.band_bkg} + 41'd1);
        num  = {sig1, 12'b0};
        rem2 = {r_rem, r_num_lo[31]};
        ge   = rem2 >= {1'b0, r_den};
    end

    // Smoothing, clamp and frame decision
    always_comb begin
        inst    = r_sat ? 32'hFFFF_FFFF : r_quo;
        alpha   = r_phase ? i_cfg.snr_alphas[31:16] : i_cfg.snr_alphas[15:0];
        old_snr = r_phase ? r_full : r_band_snr[bidx];
        psum    = {18'b0, r_p0} + {1'b0, r_p1};
        vraw    = psum[49:16];
        if (vraw > {18'b0, SNR_MAX}) snr_new = SNR_MAX;
        else if (vraw < {18'b0, SNR_MIN}) snr_new = SNR_MIN;
        else snr_new = vraw[15:0];
        speech  = (r_hits >= i_cfg.band_cnt_thr) & (snr_new > i_cfg.full_snr_thr);
        spc_inc = (r_spc == CNT_MAX) ? r_spc : r_spc + 16'd1;
        slc_inc = (r_slc == CNT_MAX) ? r_slc : r_slc + 16'd1;
    end

    // Floor walk arithmetic
    always_comb begin
        if (!r_flag) a_sel = i_cfg.floor_alphas[15:0];
        else if (r_x > r_old) a_sel = i_cfg.floor_alphas[47:32];
        else a_sel = i_cfg.floor_alphas[31:16];
        diff       = $signed({1'b0, r_x}) - $signed({1'b0, r_old});
        oldx       = $signed({19'b0, r_old2});
        new_floor  = 32'(oldx + (r_prod >>> 16));
        floor_keep = r_walk_en ? new_floor : r_old2;
        fl_we      = o_bstat.clearing | (r_v2 & r_walk_en);
        fl_wa      = o_bstat.clearing ? r_widx[BIN_AW-1:0] : r_idx2;
        fl_wd      = o_bstat.clearing ? 32'd0 : new_floor;
    end

    // Bin store: front writes, walk reads
    always_ff @(posedge i_clk) begin
        if (i_wr.we) r_store[i_wr.addr] <= i_wr.data;
        r_x <= r_store[r_widx[BIN_AW-1:0]];
    end

    // Floor memory: clear pass and walk write-back
    always_ff @(posedge i_clk) begin
        if (fl_we) r_floor[fl_wa] <= fl_wd;
        r_old <= r_floor[r_widx[BIN_AW-1:0]];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_widx      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_full      <= '0;
            r_spc       <= '0;
            r_slc       <= '0;
            r_flag      <= 1'b0;
            r_hits      <= '0;
            r_phase     <= 1'b0;
            for (int i = 0; i < NUM_BANDS; i++) r_band_snr[i] <= '0;
        end else begin
            r_state <= n_state;
            // Load a result when the register is free, drop it once taken
            if (r_state == ST_OUT && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            r_v1 <= (r_state == ST_WALK) && (r_widx != POS_W'(NUM_BINS));
            r_v2 <= r_v1;
            case (r_state)
                ST_CLEAR: r_widx <= r_widx + 1'b1;
                ST_IDLE:  r_phase <= ~i_fifo_empty & ~i_job.is_band;
                ST_APPLY: begin
                    if (r_phase) begin
                        r_full    <= snr_new;
                        r_widx    <= '0;
                        if (speech) begin
                            r_spc <= spc_inc;
                            if (spc_inc >= i_cfg.speech_hold) begin
                                r_flag <= 1'b1;
                                r_slc  <= '0;
                            end
                        end else begin
                            r_slc <= slc_inc;
                            if (slc_inc >= i_cfg.silence_hold) begin
                                r_flag <= 1'b0;
                                r_spc  <= '0;
                            end
                        end
                    end else begin
                        r_band_snr[bidx] <= snr_new;
                        if (r_job.band >= FIRST_BAND && snr_new >= i_cfg.band_snr_thr
                            && r_hits < HITS_MAX)
                            r_hits <= r_hits + 1'b1;
                        r_phase <= 1'b1;
                    end
                end
                ST_WALK: begin
                    if (r_widx != POS_W'(NUM_BINS)) r_widx <= r_widx + 1'b1;
                end
                ST_OUT: begin
                    if (out_free) r_hits <= '0;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        case (r_state)
            ST_PREP: begin
                r_num_lo <= num[31:0];
                r_rem    <= {20'b0, num[52:32]};
                r_den    <= den1;
                r_sat    <= ({20'b0, num[52:32]} >= den1);
                r_cnt    <= 5'd31;
                r_quo    <= '0;
            end
            ST_DIV: begin
                r_rem    <= ge ? 41'(rem2 - {1'b0, r_den}) : rem2[40:0];
                r_quo    <= {r_quo[30:0], ge};
                r_num_lo <= {r_num_lo[30:0], 1'b0};
                r_cnt    <= r_cnt - 5'd1;
            end
            ST_MUL: begin
                r_p0 <= alpha * old_snr;
                r_p1 <= (ONE_Q16 - {1'b0, alpha}) * inst;
            end
            ST_APPLY: begin
                r_walk_en <= r_job.frame_bkg < i_cfg.energy_limit;
                r_energy  <= '0;
            end
            ST_OUT: begin
                // Hold the pending result until the receiver takes it
                if (out_free) begin
                    r_out.speech_active     <= r_flag;
                    r_out.fullband_snr_out  <= r_full;
                    r_out.speech_band_count <= r_hits;
                    r_out.floor_energy      <= r_energy;
                end
            end
            default: ;
        endcase
        // Walk pipeline: read, multiply, write back and sum
        r_idx1 <= r_widx[BIN_AW-1:0];
        r_idx2 <= r_idx1;
        r_old2 <= r_old;
        r_prod <= diff * $signed({1'b0, ONE_Q16 - {1'b0, a_sel}});
        if (r_v2) r_energy <= sat_add(r_energy, floor_keep);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SVAD_ASSERT_IMPL(a_pop_idle, o_pop, r_state == ST_IDLE)
    `SVAD_ASSERT_IMPL(a_div_rem, r_state == ST_DIV && !r_sat, r_rem < r_den)
    `SVAD_ASSERT_IMPL(a_full_range, r_state == ST_OUT,
        r_full >= SNR_MIN && r_full <= SNR_MAX)
    `SVAD_ASSERT_NEXT(a_done_out, o_bstat.frame_done, r_out_valid && r_state == ST_IDLE)

endmodule

@@ rtl/subband_snr_voice_activity_top.sv @@
// Top level of the subband SNR voice activity detector: configuration registers,
// front, job queue and back. Depends on svad_pkg, svad_front, svad_fifo, svad_back.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall / i_in_data) takes one frequency bin per
//   transaction. Bins of a frame arrive in order; frame_end marks the last one.
// - Output channel (o_out_valid / i_out_stall / o_out_data) carries one result per
//   frame: speech flag, fullband SNR, speech band count and floor energy.
// - Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is high.
// - A band end queues a band job that the shared one-bit-per-cycle divider serves;
//   the two-entry queue absorbs bursts, and input stalls when it is full.
// - A frame end runs the fullband SNR and then a walk over all NUM_BINS floor
//   entries through the floor memory port. Input stays stalled from the frame end
//   until its result is loaded.
// - After reset all NUM_BINS floor memory entries are cleared; input is stalled.
// - When the receiver stalls, the result holds and the next frame waits for it.
module subband_snr_voice_activity_top import svad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in         i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out        o_out_data,
    input  logic        i_out_stall,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_bstat    bstat;
    t_store_wr wr;
    t_job      push_job, pop_job;
    logic      push, pop, full, empty;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.snr_alphas   <= '0;
            r_cfg.floor_alphas <= '0;
            r_cfg.band_snr_thr <= SNR_MIN;
            r_cfg.band_cnt_thr <= '0;
            r_cfg.full_snr_thr <= SNR_MIN;
            r_cfg.speech_hold  <= '0;
            r_cfg.silence_hold <= '0;
            r_cfg.energy_limit <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SNR_ALPHAS:   r_cfg.snr_alphas   <= i_cfg_data[31:0];
                CFG_FLOOR_ALPHAS: r_cfg.floor_alphas <= i_cfg_data;
                CFG_BAND_SNR_THR: r_cfg.band_snr_thr <= i_cfg_data[15:0];
                CFG_BAND_CNT_THR: r_cfg.band_cnt_thr <= i_cfg_data[5:0];
                CFG_FULL_SNR_THR: r_cfg.full_snr_thr <= i_cfg_data[15:0];
                CFG_SPEECH_HOLD:  r_cfg.speech_hold  <= i_cfg_data[15:0];
                CFG_SILENCE_HOLD: r_cfg.silence_hold <= i_cfg_data[15:0];
                CFG_ENERGY_LIMIT: r_cfg.energy_limit <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    svad_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_bstat     (bstat),
        .i_fifo_full (full),
        .o_push      (push),
        .o_job       (push_job),
        .o_wr        (wr)
    );

    svad_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_full  (full),
        .o_empty (empty)
    );

    svad_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_wr         (wr),
        .i_fifo_empty (empty),
        .i_job        (pop_job),
        .o_pop        (pop),
        .o_bstat      (bstat),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule
